[rtl/core/radix_token_parse_max_abs_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the radix token parser.
// ----------------------------------------------------------------------------
`ifndef RADIX_TOKEN_PARSE_MAX_ABS_MACROS_SVH
`define RADIX_TOKEN_PARSE_MAX_ABS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rtpma_pkg.sv]
// ----------------------------------------------------------------------------
// rtpma_pkg
// Types, status codes, character constants and helpers of the radix token
// parser.
// ----------------------------------------------------------------------------
package rtpma_pkg;

    localparam int ACC_W  = 64;
    localparam int BASE_W = 6;
    localparam int PROD_W = ACC_W + BASE_W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADDIGIT = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NOVALUES = 2'd3;

    localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BASE_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    localparam logic [PROD_W-1:0] POS_LIMIT = 70'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [PROD_W-1:0] NEG_LIMIT = 70'h0_8000_0000_0000_0000;

    typedef struct packed {
        logic              alnum;
        logic [BASE_W-1:0] value;
    } digit_t;

    // Classified character as it travels from the front end to the back end.
    typedef struct packed {
        logic              stop;
        logic              last;
        logic              minus;
        logic              digit_ok;
        logic [BASE_W-1:0] digit;
    } item_cls_t;

    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.alnum = 1'b1;
        d.value = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = BASE_W'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d.value = BASE_W'(c - CH_UPPER_A + LETTER_OFS);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d.value = BASE_W'(c - CH_LOWER_A + LETTER_OFS);
        end else begin
            d.alnum = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] r);
        logic [BASE_W-1:0] b;
        b = r;
        if (r < RADIX_MIN) begin
            b = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            b = RADIX_MAX;
        end
        return b;
    endfunction

endpackage

[rtl/core/rtpma_if.sv]
// ----------------------------------------------------------------------------
// rtpma interfaces
// Valid/ready channels for characters, results and the radix register.
// ----------------------------------------------------------------------------
interface rtpma_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       token_last;
    logic       stop_list;

    modport source (output valid, output symbol, output token_last,
                    output stop_list, input ready);
    modport sink   (input valid, input symbol, input token_last,
                    input stop_list, output ready);
endinterface

interface rtpma_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [63:0] largest_value;
    logic               list_done;

    modport source (output valid, output status, output largest_value,
                    output list_done, input ready);
    modport sink   (input valid, input status, input largest_value,
                    input list_done, output ready);
endinterface

interface rtpma_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

[rtl/core/rtpma_front.sv]
// ----------------------------------------------------------------------------
// rtpma_front
// Accepts characters and classifies them as minus sign, valid digit or
// invalid character before they enter the queue.
// ----------------------------------------------------------------------------
module rtpma_front (
    rtpma_sym_if.sink                    sym,
    input  logic [rtpma_pkg::BASE_W-1:0] base,
    input  logic                         queue_full,
    output logic                         push,
    output rtpma_pkg::item_cls_t         push_data
);

    rtpma_pkg::digit_t dig;

    always_comb
    begin
        dig                = rtpma_pkg::digit_of(sym.symbol);
        push_data.stop     = sym.stop_list;
        push_data.last     = sym.token_last;
        push_data.minus    = (sym.symbol == rtpma_pkg::CH_MINUS);
        push_data.digit_ok = dig.alnum && (dig.value < base);
        push_data.digit    = dig.value;
    end

    assign sym.ready = !queue_full;
    assign push      = sym.valid && !queue_full;

endmodule

[rtl/core/rtpma_queue.sv]
// ----------------------------------------------------------------------------
// rtpma_queue
// Small first-in first-out queue of classified characters between the
// front end and the back end.
// ----------------------------------------------------------------------------
module rtpma_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rtpma_pkg::item_cls_t push_data,
    input  logic                 pop,
    output rtpma_pkg::item_cls_t pop_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rtpma_pkg::item_cls_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/rtpma_back.sv]
// ----------------------------------------------------------------------------
// rtpma_back
// Accumulates digits with exact overflow detection, keeps the token of
// largest magnitude and drives the result register.
// ----------------------------------------------------------------------------
module rtpma_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rtpma_pkg::BASE_W-1:0] base,
    input  logic                         empty,
    input  rtpma_pkg::item_cls_t         item,
    output logic                         pop,
    rtpma_res_if.source                  res
);

    localparam int ACC_W  = rtpma_pkg::ACC_W;
    localparam int PROD_W = rtpma_pkg::PROD_W;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             start_reg, start_next;
    logic [ACC_W-1:0] best_reg, best_next;
    logic [ACC_W-1:0] mag_reg, mag_next;
    logic             have_reg, have_next;
    logic [1:0]       err_reg, err_next;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg, out_status_next;
    logic [ACC_W-1:0] out_value_reg, out_value_next;
    logic             out_done_reg, out_done_next;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] limit;

    // A new transaction enters whenever the result register is free or drains now.
    assign pop = !empty && (!out_valid_reg || res.ready);

    always_comb
    begin
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        start_next      = start_reg;
        best_next       = best_reg;
        mag_next        = mag_reg;
        have_next       = have_reg;
        err_next        = err_reg;
        out_status_next = err_reg;
        out_value_next  = best_reg;
        out_done_next   = 1'b0;

        prod  = PROD_W'(acc_reg) * PROD_W'(base);
        sum   = prod + PROD_W'(item.digit);
        limit = neg_reg ? rtpma_pkg::NEG_LIMIT : rtpma_pkg::POS_LIMIT;

        if (item.stop) begin
            out_status_next = err_reg;
            if (err_reg == rtpma_pkg::ST_OK && !have_reg) begin
                out_status_next = rtpma_pkg::ST_NOVALUES;
            end
            out_value_next = (out_status_next == rtpma_pkg::ST_OK) ? best_reg : '0;
            out_done_next  = 1'b1;
            acc_next       = '0;
            neg_next       = 1'b0;
            start_next     = 1'b1;
            best_next      = '0;
            mag_next       = '0;
            have_next      = 1'b0;
            err_next       = rtpma_pkg::ST_OK;
        end else begin
            if (err_reg == rtpma_pkg::ST_OK) begin
                if (start_reg && item.minus) begin
                    neg_next   = 1'b1;
                    start_next = 1'b0;
                end else begin
                    start_next = 1'b0;
                    if (!item.digit_ok) begin
                        err_next = rtpma_pkg::ST_BADDIGIT;
                    end else if (sum > limit) begin
                        err_next = rtpma_pkg::ST_OVERFLOW;
                    end else begin
                        acc_next = sum[ACC_W-1:0];
                    end
                end
                // Strictly larger magnitude wins, so ties keep the earlier token.
                if (item.last && err_next == rtpma_pkg::ST_OK
                    && (!have_reg || acc_next > mag_reg)) begin
                    best_next = neg_next ? ('0 - acc_next) : acc_next;
                    mag_next  = acc_next;
                    have_next = 1'b1;
                end
            end
            if (item.last) begin
                acc_next   = '0;
                neg_next   = 1'b0;
                start_next = 1'b1;
            end
            out_status_next = err_next;
            out_value_next  = best_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            start_reg     <= 1'b1;
            best_reg      <= '0;
            mag_reg       <= '0;
            have_reg      <= 1'b0;
            err_reg       <= rtpma_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                start_reg <= start_next;
                best_reg  <= best_next;
                mag_reg   <= mag_next;
                have_reg  <= have_next;
                err_reg   <= err_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (res.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_done_reg   <= out_done_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.largest_value = out_value_reg;
    assign res.list_done     = out_done_reg;

endmodule

[rtl/core/radix_token_parse_max_abs.sv]
// ----------------------------------------------------------------------------
// radix_token_parse_max_abs: radix token parser keeping the largest magnitude
// An accepted character is stored in the queue and then registered in the result register.
// Throughput is one character per cycle while the result side does not stall.
// Reset clears the token and list state, empties the queue and loads radix 10.
// ----------------------------------------------------------------------------
module radix_token_parse_max_abs #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    rtpma_sym_if.sink   sym,
    rtpma_res_if.source res,
    rtpma_cfg_if.sink   cfg
);

    logic [rtpma_pkg::BASE_W-1:0] radix_reg;
    logic [rtpma_pkg::BASE_W-1:0] base;
    logic                         push;
    logic                         pop;
    logic                         queue_full;
    logic                         queue_empty;
    rtpma_pkg::item_cls_t         push_data;
    rtpma_pkg::item_cls_t         pop_data;

    assign cfg.ready = 1'b1;
    assign base      = rtpma_pkg::clamp_radix(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= rtpma_pkg::RADIX_RESET;
        end else if (cfg.valid) begin
            radix_reg <= cfg.radix;
        end
    end

    rtpma_front u_front (
        .sym        (sym),
        .base       (base),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    rtpma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    rtpma_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .base  (base),
        .empty (queue_empty),
        .item  (pop_data),
        .pop   (pop),
        .res   (res)
    );

endmodule

[rtl/core/rtpma_checker.sv]
// ----------------------------------------------------------------------------
// rtpma_checker
// Port-level assertions on the result channel of the radix token parser.
// ----------------------------------------------------------------------------
`include "radix_token_parse_max_abs_macros.svh"

module rtpma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_status,
    input logic signed [63:0] res_value,
    input logic               res_done
);

    `RTPMA_ASSERT_NEXT(a_res_valid_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result valid dropped while stalled")
    `RTPMA_ASSERT_NEXT(a_res_data_hold, clk, rst_n, res_valid && !res_ready, $stable(res_status) && $stable(res_value) && $stable(res_done), "result payload changed while stalled")
    `RTPMA_ASSERT_NOW(a_novalues_on_stop, clk, rst_n, res_valid && !res_done, res_status != rtpma_pkg::ST_NOVALUES, "no-values status on a character transaction")
    `RTPMA_ASSERT_NOW(a_error_zero_value, clk, rst_n, res_valid && res_done && res_status != rtpma_pkg::ST_OK, res_value == 64'sd0, "nonzero value on a failed list report")

endmodule

bind radix_token_parse_max_abs rtpma_checker u_rtpma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_status(res.status),
    .res_value (res.largest_value),
    .res_done  (res.list_done)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Radix token parser testbench
// Sends characters and stop items to the parser and compares every result
// with an in-bench model of the token parser or with a result typed into a
// directed row. A short directed table covers the special cases. Random lists
// of numerals then follow in several radix settings, with random gaps on the
// input side and random stalls on the result side outside the final phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          CYCLE_LIMIT    = 600000;
    localparam int          PHASE_ITEMS    = 120;
    localparam int          NUM_PHASES     = 10;
    localparam int          NUM_ROWS       = 25;
    localparam logic [63:0] MAG_POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG_MAX    = 64'h8000_0000_0000_0000;
    localparam logic [7:0]  NOT_ALNUM      = 8'hFF;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] value;
        logic               done;
    } parse_report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [7:0]         sym;
        logic               last;
        logic               stop;
        logic               typed;
        logic [1:0]         st;
        logic signed [63:0] val;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rtpma_sym_if sym_ch ();
    rtpma_res_if res_ch ();
    rtpma_cfg_if cfg_ch ();

    radix_token_parse_max_abs u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .sym   (sym_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // Model state of the parser.
    logic [5:0]  radix_now = rtpma_pkg::RADIX_RESET;
    logic [63:0] mag_acc   = '0;
    logic        neg_tok   = 1'b0;
    logic        tok_fresh = 1'b1;
    logic [63:0] best_val  = '0;
    logic        best_seen = 1'b0;
    logic [1:0]  err_code  = rtpma_pkg::ST_OK;

    parse_report_t parse_reports[$];
    int            mismatch_count = 0;

    // Directed rows may carry a result typed in by hand.
    logic               row_typed  = 1'b0;
    logic [1:0]         row_status = rtpma_pkg::ST_OK;
    logic signed [63:0] row_value  = '0;

    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          gen_base = 10;
    logic [63:0] last_mag = '0;
    int          timeout_cycles;
    int          sent_total = 0;

    function automatic logic [7:0] alnum_value(input logic [7:0] c);
        logic [7:0] v;
        v = NOT_ALNUM;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        else if (c >= "A" && c <= "Z")
        begin
            v = c - "A" + 8'd10;
        end
        else if (c >= "a" && c <= "z")
        begin
            v = c - "a" + 8'd10;
        end
        return v;
    endfunction

    function automatic logic [7:0] digit_char(input logic [7:0] v, input bit upper);
        logic [7:0] c;
        if (v < 8'd10)
        begin
            c = rtpma_pkg::CH_ZERO + v;
        end
        else
        begin
            c = (upper ? rtpma_pkg::CH_UPPER_A : rtpma_pkg::CH_LOWER_A) + v - 8'd10;
        end
        return c;
    endfunction

    task automatic track_symbol(input logic [7:0] c, input logic last, input logic stop,
                                output parse_report_t rep);
        logic [63:0] base;
        logic [63:0] d;
        logic [63:0] lim;
        logic [63:0] best_mag;
        logic [1:0]  st;
        if (stop)
        begin
            st = err_code;
            if (st == rtpma_pkg::ST_OK && !best_seen)
            begin
                st = rtpma_pkg::ST_NOVALUES;
            end
            rep.status = st;
            rep.value  = (st == rtpma_pkg::ST_OK) ? best_val : '0;
            rep.done   = 1'b1;
            mag_acc    = '0;
            neg_tok    = 1'b0;
            tok_fresh  = 1'b1;
            best_val   = '0;
            best_seen  = 1'b0;
            err_code   = rtpma_pkg::ST_OK;
        end
        else
        begin
            if (err_code == rtpma_pkg::ST_OK)
            begin
                base = 64'((radix_now < rtpma_pkg::RADIX_MIN) ? rtpma_pkg::RADIX_MIN
                         : (radix_now > rtpma_pkg::RADIX_MAX) ? rtpma_pkg::RADIX_MAX
                         : radix_now);
                if (tok_fresh && c == rtpma_pkg::CH_MINUS)
                begin
                    neg_tok   = 1'b1;
                    tok_fresh = 1'b0;
                end
                else
                begin
                    tok_fresh = 1'b0;
                    d = 64'(alnum_value(c));
                    if (d >= base)
                    begin
                        err_code = rtpma_pkg::ST_BADDIGIT;
                    end
                    else
                    begin
                        lim = neg_tok ? MAG_NEG_MAX : MAG_POS_MAX;
                        if (mag_acc > (lim - d) / base)
                        begin
                            err_code = rtpma_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            mag_acc = mag_acc * base + d;
                        end
                    end
                end
                if (last && err_code == rtpma_pkg::ST_OK)
                begin
                    best_mag = best_val[63] ? -best_val : best_val;
                    // Only a strictly larger magnitude replaces the earlier token.
                    if (!best_seen || mag_acc > best_mag)
                    begin
                        best_val  = neg_tok ? -mag_acc : mag_acc;
                        best_seen = 1'b1;
                    end
                end
            end
            if (last)
            begin
                mag_acc   = '0;
                neg_tok   = 1'b0;
                tok_fresh = 1'b1;
            end
            rep.status = err_code;
            rep.value  = best_val;
            rep.done   = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        parse_report_t rep;
        parse_report_t want;
        if (rst_n)
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                track_symbol(sym_ch.symbol, sym_ch.token_last, sym_ch.stop_list, rep);
                if (row_typed)
                begin
                    rep.status = row_status;
                    rep.value  = row_value;
                    rep.done   = sym_ch.stop_list;
                end
                parse_reports.push_back(rep);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (parse_reports.size() == 0)
                begin
                    $display("%0t: result with none outstanding: status %0d value %0d done %0b",
                             $time, res_ch.status, res_ch.largest_value, res_ch.list_done);
                    mismatch_count++;
                end
                else
                begin
                    want = parse_reports.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, res_ch.status);
                        mismatch_count++;
                    end
                    if (res_ch.largest_value !== want.value)
                    begin
                        $display("%0t: largest_value mismatch: expected %0d, actual %0d",
                                 $time, want.value, res_ch.largest_value);
                        mismatch_count++;
                    end
                    if (res_ch.list_done !== want.done)
                    begin
                        $display("%0t: list_done mismatch: expected %0b, actual %0b",
                                 $time, want.done, res_ch.list_done);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                radix_now = cfg_ch.radix;
            end
        end
    end

    // Result-side back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            res_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end
        else
        begin
            res_ch.ready = 1'b1;
        end
    end

    initial
    begin
        for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++)
        begin
            @(posedge clk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Entered and left at a falling edge; valid stays high into the next call.
    task automatic send_symbol(input logic [7:0] s, input logic last, input logic stop);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sym_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        sym_ch.valid      = 1'b1;
        sym_ch.symbol     = s;
        sym_ch.token_last = last;
        sym_ch.stop_list  = stop;
        @(posedge clk);
        while (!sym_ch.ready)
        begin
            @(posedge clk);
        end
        sent_total++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sym_ch.valid = 1'b0;
        while (parse_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_radix(input logic [5:0] r);
        wait_idle();
        cfg_ch.valid = 1'b1;
        cfg_ch.radix = r;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_numeral(input bit cut);
        logic [63:0] mag;
        logic [7:0]  chars[$];
        bit          neg;
        int          n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mag = 64'($urandom_range(0, 999));
            4:          mag = {$urandom, $urandom} >> $urandom_range(1, 63);
            5:          mag = {$urandom, $urandom};
            6:          mag = MAG_POS_MAX + 64'($urandom_range(0, 2));
            7:          mag = last_mag;
            8:          mag = '1;
            default:    mag = 64'($urandom_range(0, 35));
        endcase
        neg = 1'($urandom_range(0, 1));
        last_mag = mag;
        do
        begin
            chars.push_front(digit_char(8'(mag % gen_base), 1'($urandom_range(0, 1))));
            mag = mag / gen_base;
        end
        while (mag != 0);
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 2)) chars.push_front(rtpma_pkg::CH_ZERO);
        end
        // An extra trailing digit pushes large values past the limit.
        if ($urandom_range(0, 15) == 0)
        begin
            chars.push_back(digit_char(8'($urandom_range(0, gen_base - 1)),
                                       1'($urandom_range(0, 1))));
        end
        if (neg)
        begin
            chars.push_front(rtpma_pkg::CH_MINUS);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
        n = cut ? $urandom_range(1, chars.size()) : chars.size();
        for (int i = 0; i < n; i++)
        begin
            send_symbol(chars[i], !cut && i == n - 1, 1'b0);
        end
    endtask

    task automatic send_noise(input bit cut);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            send_symbol(($urandom_range(0, 3) == 0) ? rtpma_pkg::CH_MINUS
                                                    : 8'($urandom_range(0, 255)),
                        !cut && i == n - 1, 1'b0);
        end
    endtask

    task automatic send_list();
        int  ntok;
        bit  cut;
        ntok = $urandom_range(0, 5);
        for (int t = 0; t < ntok; t++)
        begin
            // Occasionally the list stops in the middle of its last token.
            cut = (t == ntok - 1) && ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 19) < 17)
            begin
                send_numeral(cut);
            end
            else
            begin
                send_noise(cut);
            end
        end
        send_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    stim_row_t  directed_rows [NUM_ROWS];
    logic [5:0] phase_radix [NUM_PHASES];
    int         sent_before;

    initial
    begin
        sym_ch.valid      = 1'b0;
        sym_ch.symbol     = '0;
        sym_ch.token_last = 1'b0;
        sym_ch.stop_list  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.radix      = rtpma_pkg::RADIX_RESET;

        directed_rows = '{
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, rtpma_pkg::ST_NOVALUES, 64'sd0},
            '{ROW_ITEM, rtpma_pkg::CH_MINUS, 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, rtpma_pkg::CH_MINUS, 1'b0, 1'b0, 1'b1, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "5", 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_OK, -64'sd5},
            '{ROW_ITEM, "5", 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_OK, -64'sd5},
            '{ROW_ITEM, "7", 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, rtpma_pkg::CH_MINUS, 1'b0, 1'b0, 1'b1, rtpma_pkg::ST_BADDIGIT,
              -64'sd5},
            '{ROW_ITEM, "3", 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_BADDIGIT, -64'sd5},
            '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 1'b1, rtpma_pkg::ST_BADDIGIT, 64'sd0},
            '{ROW_ITEM, "#", 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_BADDIGIT, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, rtpma_pkg::ST_BADDIGIT, 64'sd0},
            '{ROW_ITEM, "1", 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, rtpma_pkg::ST_NOVALUES, 64'sd0},
            '{ROW_CFG,  8'd36, 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "z", 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "Z", 1'b1, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "a", 1'b1, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_CFG,  8'd0, 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "2", 1'b1, 1'b0, 1'b1, rtpma_pkg::ST_BADDIGIT, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, rtpma_pkg::ST_BADDIGIT, 64'sd0},
            '{ROW_CFG,  8'd63, 1'b0, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, "z", 1'b1, 1'b0, 1'b0, rtpma_pkg::ST_OK, 64'sd0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, rtpma_pkg::ST_OK, 64'sd0}
        };
        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd63, 6'd8, 6'd37, 6'd1, 6'd20};
        phase_radix[NUM_PHASES - 1] = 6'($urandom_range(2, 36));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                write_radix(directed_rows[i].sym[5:0]);
            end
            else
            begin
                row_typed  = directed_rows[i].typed;
                row_status = directed_rows[i].st;
                row_value  = directed_rows[i].val;
                send_symbol(directed_rows[i].sym, directed_rows[i].last,
                            directed_rows[i].stop);
            end
        end
        row_typed = 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_radix(phase_radix[p]);
            gen_base = (phase_radix[p] < rtpma_pkg::RADIX_MIN) ? rtpma_pkg::RADIX_MIN
                     : (phase_radix[p] > rtpma_pkg::RADIX_MAX) ? rtpma_pkg::RADIX_MAX
                     : phase_radix[p];
            // No idling in the final phase.
            idle_on = (p != NUM_PHASES - 1);
            sent_before = sent_total;
            while (sent_total - sent_before < PHASE_ITEMS)
            begin
                send_list();
            end
        end

        sym_ch.valid = 1'b0;
        while (parse_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (mismatch_count == 0 && parse_reports.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rtpma_pkg.sv
rtl/core/rtpma_if.sv
rtl/core/rtpma_front.sv
rtl/core/rtpma_queue.sv
rtl/core/rtpma_back.sv
rtl/core/radix_token_parse_max_abs.sv
rtl/core/rtpma_checker.sv
tb/sv/testbench.sv
